// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 8;

  // fixed payload widths of the channels
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_POP    = 1'b1
  } func_t;

  typedef logic [KIND_W-1:0] kind_t;

  // control broadcast to every cell
  typedef struct packed {
    logic  shift_en;
    func_t func;
  } cell_ctrl_t;

endpackage

// ===== sv/spq_op_if.sv =====
// ----------------------------------------------------------------------------
// spq_op_if
// Operation channel: insert or pop request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_op_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [KEY_W-1:0]     entry_key;
  logic [KIND_W-1:0]    entry_kind;

  modport source (output valid, output func, output entry_key, output entry_kind,
                  input ready);
  modport sink   (input valid, input func, input entry_key, input entry_kind,
                  output ready);
endinterface

// ===== sv/spq_res_if.sv =====
// ----------------------------------------------------------------------------
// spq_res_if
// Result channel: popped entry, status flags and entry count.
// ----------------------------------------------------------------------------
interface spq_res_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     out_key;
  logic [KIND_W-1:0]    out_kind;
  logic                 out_valid;
  logic                 was_empty;
  logic                 overflow;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, output out_key, output out_kind, output out_valid,
                  output was_empty, output overflow, output entry_count,
                  input ready);
  modport sink   (input valid, input out_key, input out_kind, input out_valid,
                  input was_empty, input overflow, input entry_count,
                  output ready);
endinterface

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming key and either keeps it, loads the new entry or shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
  input  logic                  clk,
  input  spq_pkg::cell_ctrl_t   ctrl,
  input  logic [KEY_BITS-1:0]   new_key,
  input  spq_pkg::kind_t        new_kind,
  input  logic                  occupied,
  input  logic                  prev_gt,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  spq_pkg::kind_t        prev_kind,
  input  logic [KEY_BITS-1:0]   next_key,
  input  spq_pkg::kind_t        next_kind,
  output logic                  gt,
  output logic [KEY_BITS-1:0]   key,
  output spq_pkg::kind_t        kind
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0] key_next;
  kind_t               kind_next;

  assign gt = occupied && (key > new_key);

  always_comb begin
    key_next  = key;
    kind_next = kind;
    case (ctrl.func)
      FUNC_POP: begin
        key_next  = next_key;
        kind_next = next_kind;
      end
      FUNC_INSERT: begin
        if (!gt) begin
          // insertion point is the first slot whose left neighbor is larger
          if (prev_gt) begin
            key_next  = new_key;
            kind_next = new_kind;
          end else begin
            key_next  = prev_key;
            kind_next = prev_kind;
          end
        end
      end
      default: begin
        key_next  = key;
        kind_next = kind;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      key  <= key_next;
      kind <= kind_next;
    end
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in descending key order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   op  : sink channel; func selects insert (entry_key, entry_kind) or pop.
//   res : source channel; one beat per op beat with the popped entry,
//         out_valid / was_empty / overflow flags and the count afterwards.
//   Every cell compares its key with the incoming key in parallel, so an
//   insert or pop is done at once in all cells; the result beat appears in the
//   output register the cycle after the op beat is taken.
//   One op per cycle unless res stalls; the output register is the only
//   stage, so op.ready follows res.ready while a result is held.
//   Equal keys are served newest first. An insert into a full queue and a
//   pop from an empty queue leave the contents untouched.
//   Reset clears the entry count and the result valid flag; slot contents
//   are not cleared since only occupied slots are ever read.
//   When the receiver stalls, the result is held and no new op is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  spq_op_if.sink   op,
  spq_res_if.source res
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic [KEY_BITS-1:0] in_key;
  cell_ctrl_t          ctrl;

  logic [KEY_BITS-1:0] cell_key  [DEPTH];
  kind_t               cell_kind [DEPTH];
  logic                cell_gt   [DEPTH];

  logic [KEY_W-1:0]    head_key;
  logic [KEY_W-1:0]    res_key_next;
  kind_t               res_kind_next;
  logic                res_out_valid_next;
  logic                res_empty_next;
  logic                res_ovf_next;

  assign op.ready = !res.valid || res.ready;
  assign accept   = op.valid && op.ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // key masked or zero-extended to the stored width
  assign in_key   = KEY_BITS'(op.entry_key);
  assign head_key = KEY_W'(cell_key[0]);

  always_comb begin
    ctrl.func     = op.func;
    ctrl.shift_en = 1'b0;
    count_next    = count;
    res_key_next       = '0;
    res_kind_next      = '0;
    res_out_valid_next = 1'b0;
    res_empty_next     = 1'b0;
    res_ovf_next       = 1'b0;
    case (op.func)
      FUNC_INSERT: begin
        if (full) begin
          res_ovf_next = 1'b1;
        end else begin
          ctrl.shift_en = accept;
          count_next    = count + CNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (empty) begin
          res_empty_next = 1'b1;
        end else begin
          ctrl.shift_en      = accept;
          count_next         = count - CNT_W'(1);
          res_key_next       = head_key;
          res_kind_next      = cell_kind[0];
          res_out_valid_next = 1'b1;
        end
      end
      default: begin
        ctrl.shift_en = 1'b0;
      end
    endcase
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                occ;
      logic                left_gt;
      logic [KEY_BITS-1:0] left_key;
      kind_t               left_kind;
      logic [KEY_BITS-1:0] right_key;
      kind_t               right_kind;

      assign occ = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        // the head acts as if a larger entry sat to its left
        assign left_gt   = 1'b1;
        assign left_key  = in_key;
        assign left_kind = op.entry_kind;
      end else begin : g_body
        assign left_gt   = cell_gt[i-1];
        assign left_key  = cell_key[i-1];
        assign left_kind = cell_kind[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign right_key  = cell_key[i];
        assign right_kind = cell_kind[i];
      end else begin : g_inner
        assign right_key  = cell_key[i+1];
        assign right_kind = cell_kind[i+1];
      end

      spq_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_key   (in_key),
        .new_kind  (op.entry_kind),
        .occupied  (occ),
        .prev_gt   (left_gt),
        .prev_key  (left_key),
        .prev_kind (left_kind),
        .next_key  (right_key),
        .next_kind (right_kind),
        .gt        (cell_gt[i]),
        .key       (cell_key[i]),
        .kind      (cell_kind[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res.out_key     <= res_key_next;
      res.out_kind    <= res_kind_next;
      res.out_valid   <= res_out_valid_next;
      res.was_empty   <= res_empty_next;
      res.overflow    <= res_ovf_next;
      res.entry_count <= COUNT_W'(count_next);
    end
  end

endmodule

// ===== tb/sorted_priority_queue_test.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. Op beats go in through
// the op channel; a shadow queue kept in descending key order predicts every
// result beat, and a monitor compares each field in arrival order. Both
// channels see random gaps, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned KEY_BITS     = KEY_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    kind_t              kind;
    logic               popped;
    logic               was_empty;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic clk;
  logic rst;

  spq_op_if  op_bus ();
  spq_res_if res_bus ();

  sorted_priority_queue #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .op  (op_bus),
    .res (res_bus)
  );

  // shadow copy of the queue contents, head at index 0
  logic [KEY_BITS-1:0] shadow_keys  [DEPTH];
  kind_t               shadow_kinds [DEPTH];
  int unsigned         shadow_count;

  queue_result_t pending_results [$];
  int unsigned   mismatch_count;
  bit            steady_flow;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic queue_result_t predict_queue_op(func_t f, logic [KEY_W-1:0] key,
                                                     kind_t kind);
    queue_result_t r;
    logic [KEY_BITS-1:0] k;
    int unsigned pos;
    r = '0;
    k = key[KEY_BITS-1:0];
    if (f == FUNC_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        // new entry goes ahead of every entry with an equal or smaller key
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] > k) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i]  = shadow_keys[i-1];
          shadow_kinds[i] = shadow_kinds[i-1];
        end
        shadow_keys[pos]  = k;
        shadow_kinds[pos] = kind;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.was_empty = 1'b1;
      end else begin
        r.key    = KEY_W'(shadow_keys[0]);
        r.kind   = shadow_kinds[0];
        r.popped = 1'b1;
        for (int i = 1; i < shadow_count; i++) begin
          shadow_keys[i-1]  = shadow_keys[i];
          shadow_kinds[i-1] = shadow_kinds[i];
        end
        shadow_count--;
      end
    end
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result beats are checked before the op beat of the same edge is predicted
  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no outstanding op");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_key", want.key, res_bus.out_key);
          check_field("out_kind", want.kind, res_bus.out_kind);
          check_field("out_valid", want.popped, res_bus.out_valid);
          check_field("was_empty", want.was_empty, res_bus.was_empty);
          check_field("overflow", want.overflow, res_bus.overflow);
          check_field("entry_count", want.count, res_bus.entry_count);
        end
      end
      if (op_bus.valid && op_bus.ready)
        pending_results.push_back(predict_queue_op(op_bus.func, op_bus.entry_key,
                                                   op_bus.entry_kind));
    end
  end

  // receiver back-pressure
  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) break;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_queue_op(func_t f, logic [KEY_W-1:0] key, kind_t kind);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      op_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op_bus.valid      <= 1'b1;
    op_bus.func       <= f;
    op_bus.entry_key  <= key;
    op_bus.entry_kind <= kind;
    do @(posedge clk); while (!op_bus.ready);
  endtask

  task automatic idle_op_channel();
    @(negedge clk);
    op_bus.valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    idle_op_channel();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic func_t pick_func(int unsigned insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
  endfunction

  // empty pop, fill with extreme and tied keys, refused insert, then some pops
  task automatic test_directed_edges();
    logic [KEY_W-1:0] fill_keys [16];
    fill_keys = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd1, 8'd254, 8'd127,
                  8'd129, 8'd64, 8'd0, 8'd255, 8'd170, 8'd85, 8'd2, 8'd128};
    push_queue_op(FUNC_POP, '1, '1);
    for (int i = 0; i < 16; i++)
      push_queue_op(FUNC_INSERT, fill_keys[i], kind_t'(i % 4));
    push_queue_op(FUNC_INSERT, 8'd200, 2'd1);
    repeat (6) push_queue_op(FUNC_POP, '0, '0);
  endtask

  // alternating fill-heavy and drain-heavy blocks to hit full and empty often
  task automatic test_fill_drain_cycles();
    for (int blk = 0; blk < 8; blk++)
      repeat (40)
        push_queue_op(pick_func((blk % 2 == 0) ? 80 : 20), KEY_W'($urandom_range(0, 255)),
                      kind_t'($urandom_range(0, 3)));
  endtask

  // narrow key range so equal keys pile up; pause midway until all results are in
  task automatic test_tied_keys();
    for (int i = 0; i < 200; i++) begin
      if (i == 100) wait_results_drained();
      push_queue_op(pick_func(55), KEY_W'($urandom_range(0, 3)),
                    kind_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    for (int i = 0; i < 180; i++)
      push_queue_op(pick_func(((i / 45) % 2 == 0) ? 70 : 30),
                    KEY_W'($urandom_range(0, 255)), kind_t'($urandom_range(0, 3)));
    steady_flow = 1'b0;
  endtask

  task automatic test_random_mix();
    repeat (130)
      push_queue_op(pick_func(50), KEY_W'($urandom_range(0, 255)),
                    kind_t'($urandom_range(0, 3)));
  endtask

  initial begin
    mismatch_count = 0;
    steady_flow    = 1'b0;
    shadow_count   = 0;
    rst               <= 1'b1;
    op_bus.valid      <= 1'b0;
    op_bus.func       <= FUNC_INSERT;
    op_bus.entry_key  <= '0;
    op_bus.entry_kind <= '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_drain_cycles();
    test_tied_keys();
    test_back_to_back();
    test_random_mix();

    idle_op_channel();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
